### sv/sgdrb_pkg.sv
// Shared types, constants and the sequencer microprogram for the
// descriptor ring builder. No dependencies.
package sgdrb_pkg;

  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 22;
  localparam int CNT_W           = 16;
  localparam int CTRL_W          = 8;
  localparam int MAX_DESCRIPTORS = 64;
  localparam int DESC_BYTES      = 32;
  localparam int LIMIT_W         = LEN_W + 1;

  localparam logic [CNT_W-1:0]  CHUNK_RESET = 16'hFF00;
  localparam logic [CTRL_W-1:0] CTRL_EOP    = 8'h01;
  localparam logic [CTRL_W-1:0] CTRL_SOP    = 8'h04;
  localparam logic [CTRL_W-1:0] CTRL_OWNED  = 8'h80;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE  = 2'd0;  // take request
  localparam step_t STEP_CHECK = 2'd1;  // chunk count limit
  localparam step_t STEP_LONG  = 2'd2;  // single too_long result
  localparam step_t STEP_EMIT  = 2'd3;  // one descriptor per pass

  typedef enum logic [1:0] {
    W_NONE,
    W_INPUT,
    W_OUTPUT
  } wait_e;

  typedef enum logic [1:0] {
    C_TRUE,
    C_LEN_ZERO,
    C_TOO_LONG,
    C_LAST
  } cond_e;

  typedef struct packed {
    logic  take_in;
    logic  emit_desc;
    logic  emit_long;
    wait_e wait_sel;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic len_zero;
    logic too_long;
    logic is_last;
    logic out_free;
  } status_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic take_in;
    logic emit_desc;
    logic emit_long;
  } ctrl_t;

  function automatic uword_t program_rom(step_t step);
    uword_t w;
    w = '{take_in: 1'b0, emit_desc: 1'b0, emit_long: 1'b0, wait_sel: W_NONE,
          cond: C_TRUE, tgt_t: STEP_IDLE, tgt_f: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.take_in  = 1'b1;
        w.wait_sel = W_INPUT;
        w.cond     = C_LEN_ZERO;
        w.tgt_t    = STEP_IDLE;
        w.tgt_f    = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.cond  = C_TOO_LONG;
        w.tgt_t = STEP_LONG;
        w.tgt_f = STEP_EMIT;
      end
      STEP_LONG: begin
        w.emit_long = 1'b1;
        w.wait_sel  = W_OUTPUT;
        w.cond      = C_TRUE;
        w.tgt_t     = STEP_IDLE;
        w.tgt_f     = STEP_IDLE;
      end
      STEP_EMIT: begin
        w.emit_desc = 1'b1;
        w.wait_sel  = W_OUTPUT;
        w.cond      = C_LAST;
        w.tgt_t     = STEP_IDLE;
        w.tgt_f     = STEP_EMIT;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

### sv/sgdrb_req_if.sv
// Request channel: valid/ready plus the transfer request payload.
// Depends on sgdrb_pkg for field widths.
interface sgdrb_req_if;
  logic                          valid;
  logic                          ready;
  logic [sgdrb_pkg::ADDR_W-1:0]  start_addr;
  logic [sgdrb_pkg::LEN_W-1:0]   length;
  logic [sgdrb_pkg::ADDR_W-1:0]  table_base;

  modport source (output valid, start_addr, length, table_base, input ready);
  modport sink   (input valid, start_addr, length, table_base, output ready);
endinterface

### sv/sgdrb_desc_if.sv
// Descriptor channel: valid/ready plus one descriptor result.
// Depends on sgdrb_pkg for field widths.
interface sgdrb_desc_if;
  logic                          valid;
  logic                          ready;
  logic [sgdrb_pkg::ADDR_W-1:0]  desc_addr;
  logic [sgdrb_pkg::ADDR_W-1:0]  src_addr;
  logic [sgdrb_pkg::ADDR_W-1:0]  next_addr;
  logic [sgdrb_pkg::CNT_W-1:0]   byte_count;
  logic [sgdrb_pkg::CTRL_W-1:0]  control;
  logic                          last;
  logic                          too_long;

  modport source (output valid, desc_addr, src_addr, next_addr, byte_count, control,
                  last, too_long, input ready);
  modport sink   (input valid, desc_addr, src_addr, next_addr, byte_count, control,
                  last, too_long, output ready);
endinterface

### sv/sg_dma_descriptor_ring_builder_top.sv
// Top level of the scatter-gather descriptor ring builder.
// Depends on sgdrb_pkg, sgdrb_req_if, sgdrb_desc_if, sgdrb_sequencer, sgdrb_datapath.
//
// Usage:
//   req_i takes one request per transfer (start_addr, length, table_base).
//   desc_o gives one descriptor per chunk of at most chunk_bytes bytes, in
//   order; the last one has last=1, EOP in control and next_addr pointing
//   back at table_base, closing the ring. A zero length gives nothing. A
//   request needing more than MAX_DESCRIPTORS chunks gives one result with
//   too_long=1 and every other field zero.
//   cfg_we_i/cfg_wdata_i write chunk_bytes (0 acts as 1); write only while
//   idle. Reset value 0xFF00.
// Timing:
//   One request at a time. ready is high only in the take step. A request
//   of N descriptors passes take, limit check and N emit steps; the first
//   descriptor enters the output register in the first emit step. Too-long
//   requests pass take, limit check and the too-long step; zero length only
//   take. Emit step: one descriptor per cycle while desc_o is not stalled.
// Stall: desc_o has a single output register; while it is full and not
//   taken, the sequencer holds its emit or too-long step and the walk state holds.
// Reset (async, active low): sequencer back to the take step, output
//   register empty, chunk_bytes back to its reset value.
module sg_dma_descriptor_ring_builder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sgdrb_pkg::CNT_W-1:0] cfg_wdata_i,
  sgdrb_req_if.sink                   req_i,
  sgdrb_desc_if.source                desc_o
);

  sgdrb_pkg::status_t status;
  sgdrb_pkg::ctrl_t   ctrl;

  // control store + step counter
  sgdrb_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // walk registers, descriptor fields, output register
  sgdrb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .desc        (desc_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

endmodule

### sv/sgdrb_sequencer.sv
// Microprogram sequencer: step counter, control ROM, wait and branch logic.
// Depends on sgdrb_pkg.
module sgdrb_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgdrb_pkg::status_t status_i,
  output sgdrb_pkg::ctrl_t   ctrl_o
);

  sgdrb_pkg::step_t  step_d, step_q;
  sgdrb_pkg::uword_t uword;
  logic              stalled;
  logic              cond_hit;

  assign uword = sgdrb_pkg::program_rom(step_q);

  always_comb begin
    unique case (uword.wait_sel)
      sgdrb_pkg::W_INPUT:  stalled = !status_i.in_valid;
      sgdrb_pkg::W_OUTPUT: stalled = !status_i.out_free;
      default:             stalled = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uword.cond)
      sgdrb_pkg::C_LEN_ZERO: cond_hit = status_i.len_zero;
      sgdrb_pkg::C_TOO_LONG: cond_hit = status_i.too_long;
      sgdrb_pkg::C_LAST:     cond_hit = status_i.is_last;
      default:               cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (stalled) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = uword.tgt_t;
    end else begin
      step_d = uword.tgt_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sgdrb_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // ready is offered whenever the take step is active, independent of valid
  assign ctrl_o.take_in   = uword.take_in;
  assign ctrl_o.emit_desc = uword.emit_desc & status_i.out_free;
  assign ctrl_o.emit_long = uword.emit_long & status_i.out_free;

endmodule

### sv/sgdrb_datapath.sv
// Datapath: chunk register, walk registers, descriptor field logic and the
// output register. Depends on sgdrb_pkg and the two channel interfaces.
module sgdrb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgdrb_pkg::CNT_W-1:0]    cfg_wdata_i,
  sgdrb_req_if.sink                      req,
  sgdrb_desc_if.source                   desc,
  input  sgdrb_pkg::ctrl_t               ctrl_i,
  output sgdrb_pkg::status_t             status_o
);

  logic [sgdrb_pkg::CNT_W-1:0]   chunk_q;
  logic [sgdrb_pkg::CNT_W-1:0]   chunk_eff;
  logic [sgdrb_pkg::LEN_W-1:0]   remaining_q;
  logic [sgdrb_pkg::ADDR_W-1:0]  rd_addr_q;
  logic [sgdrb_pkg::ADDR_W-1:0]  desc_addr_q;
  logic [sgdrb_pkg::ADDR_W-1:0]  base_q;
  logic                          first_q;
  logic [sgdrb_pkg::LIMIT_W-1:0] limit;
  logic                          is_last;
  logic                          too_long;
  logic [sgdrb_pkg::CNT_W-1:0]   count;
  logic [sgdrb_pkg::ADDR_W-1:0]  desc_step;
  logic [sgdrb_pkg::ADDR_W-1:0]  next_addr;
  logic [sgdrb_pkg::CTRL_W-1:0]  control;
  logic                          out_valid_q;
  logic                          out_free;

  assign chunk_eff = (chunk_q == '0) ? sgdrb_pkg::CNT_W'(1) : chunk_q;

  // more than MAX_DESCRIPTORS chunks <=> length > MAX_DESCRIPTORS * chunk
  assign limit    = sgdrb_pkg::LIMIT_W'(chunk_eff)
                  * sgdrb_pkg::LIMIT_W'(sgdrb_pkg::MAX_DESCRIPTORS);
  assign too_long = sgdrb_pkg::LIMIT_W'(remaining_q) > limit;

  assign is_last   = remaining_q <= sgdrb_pkg::LEN_W'(chunk_eff);
  assign count     = is_last ? remaining_q[sgdrb_pkg::CNT_W-1:0] : chunk_eff;
  assign desc_step = desc_addr_q + sgdrb_pkg::ADDR_W'(sgdrb_pkg::DESC_BYTES);
  assign next_addr = is_last ? base_q : desc_step;
  assign control   = sgdrb_pkg::CTRL_OWNED
                   | (first_q ? sgdrb_pkg::CTRL_SOP : '0)
                   | (is_last ? sgdrb_pkg::CTRL_EOP : '0);

  assign out_free = !out_valid_q || desc.ready;

  assign status_o.in_valid = req.valid;
  assign status_o.len_zero = (req.length == '0);
  assign status_o.too_long = too_long;
  assign status_o.is_last  = is_last;
  assign status_o.out_free = out_free;

  assign req.ready  = ctrl_i.take_in;
  assign desc.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= sgdrb_pkg::CHUNK_RESET;
    end else if (cfg_we_i) begin
      chunk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      rd_addr_q   <= '0;
      desc_addr_q <= '0;
      base_q      <= '0;
      first_q     <= 1'b0;
    end else if (ctrl_i.take_in && req.valid) begin
      remaining_q <= req.length;
      rd_addr_q   <= req.start_addr;
      desc_addr_q <= req.table_base;
      base_q      <= req.table_base;
      first_q     <= 1'b1;
    end else if (ctrl_i.emit_desc) begin
      remaining_q <= remaining_q - sgdrb_pkg::LEN_W'(count);
      rd_addr_q   <= rd_addr_q + sgdrb_pkg::ADDR_W'(chunk_eff);
      desc_addr_q <= desc_step;
      first_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit_desc || ctrl_i.emit_long) begin
      out_valid_q <= 1'b1;
    end else if (desc.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_desc) begin
      desc.desc_addr  <= desc_addr_q;
      desc.src_addr   <= rd_addr_q;
      desc.next_addr  <= next_addr;
      desc.byte_count <= count;
      desc.control    <= control;
      desc.last       <= is_last;
      desc.too_long   <= 1'b0;
    end else if (ctrl_i.emit_long) begin
      desc.desc_addr  <= '0;
      desc.src_addr   <= '0;
      desc.next_addr  <= '0;
      desc.byte_count <= '0;
      desc.control    <= '0;
      desc.last       <= 1'b0;
      desc.too_long   <= 1'b1;
    end
  end

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_desc |-> (remaining_q != '0) && !too_long)
    else $error("descriptor emitted with nothing left or over the limit");

  a_long_only_when_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_long |-> too_long && !ctrl_i.emit_desc)
    else $error("too_long result without an oversized request");

  a_sop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_desc |=> !first_q)
    else $error("start-of-packet still pending after a descriptor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.emit_desc || ctrl_i.emit_long) |-> (!out_valid_q || desc.ready))
    else $error("output register overwritten while full");

endmodule

### tb/testbench.sv
// Self-checking testbench for sg_dma_descriptor_ring_builder_top.
// Depends on sgdrb_pkg, sgdrb_req_if, sgdrb_desc_if and the RTL under sv/.
// A ring predictor checks every descriptor in order, across idle and stall phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int PHASE_ITEMS  = 88;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned LEN_MAX = (1 << sgdrb_pkg::LEN_W) - 1;

  typedef struct packed {
    logic [sgdrb_pkg::ADDR_W-1:0] start_addr;
    logic [sgdrb_pkg::LEN_W-1:0]  length;
    logic [sgdrb_pkg::ADDR_W-1:0] table_base;
  } xfer_req_t;

  typedef struct packed {
    logic [sgdrb_pkg::ADDR_W-1:0] desc_addr;
    logic [sgdrb_pkg::ADDR_W-1:0] src_addr;
    logic [sgdrb_pkg::ADDR_W-1:0] next_addr;
    logic [sgdrb_pkg::CNT_W-1:0]  byte_count;
    logic [sgdrb_pkg::CTRL_W-1:0] control;
    logic                         last;
    logic                         too_long;
  } desc_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i;
  logic [sgdrb_pkg::CNT_W-1:0] cfg_wdata_i;

  sgdrb_req_if  req ();
  sgdrb_desc_if desc ();

  sg_dma_descriptor_ring_builder_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .desc_o      (desc)
  );

  // Shadow of chunk_bytes and the descriptors still owed by the block
  logic [sgdrb_pkg::CNT_W-1:0] chunk_reg = sgdrb_pkg::CHUNK_RESET;
  desc_t                       ring_desc_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int requests_sent  = 0;
  int descs_checked  = 0;
  int long_results   = 0;
  int cycle_count    = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d descriptors still owed", $time, ring_desc_q.size());
      $display("sg_dma_descriptor_ring_builder_top: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    desc.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic string fmt_desc(input desc_t d);
    return $sformatf("desc=%h read=%h next=%h count=%h ctrl=%h last=%b too_long=%b",
                     d.desc_addr, d.src_addr, d.next_addr, d.byte_count, d.control,
                     d.last, d.too_long);
  endfunction

  // Expected descriptor chain for one accepted request
  function automatic void predict_ring(input xfer_req_t r);
    int unsigned                  chunk;
    int unsigned                  remaining;
    int unsigned                  count;
    int unsigned                  ndesc;
    logic [sgdrb_pkg::ADDR_W-1:0] rd;
    logic [sgdrb_pkg::ADDR_W-1:0] da;
    desc_t                        d;
    chunk = (chunk_reg == '0) ? 1 : chunk_reg;
    if (r.length == '0) return;
    ndesc = (r.length + chunk - 1) / chunk;
    if (ndesc > sgdrb_pkg::MAX_DESCRIPTORS) begin
      d = '0;
      d.too_long = 1'b1;
      ring_desc_q.push_back(d);
      return;
    end
    remaining = 32'(r.length);
    rd = r.start_addr;
    da = r.table_base;
    for (int k = 0; k < ndesc; k++) begin
      d = '0;
      d.last       = (remaining <= chunk);
      count        = d.last ? remaining : chunk;
      d.desc_addr  = da;
      d.src_addr   = rd;
      d.next_addr  = d.last ? r.table_base : da + sgdrb_pkg::DESC_BYTES;
      d.byte_count = sgdrb_pkg::CNT_W'(count);
      d.control    = sgdrb_pkg::CTRL_OWNED
                   | ((k == 0) ? sgdrb_pkg::CTRL_SOP : 8'h00)
                   | (d.last ? sgdrb_pkg::CTRL_EOP : 8'h00);
      ring_desc_q.push_back(d);
      remaining -= count;
      rd = rd + chunk;
      da = da + sgdrb_pkg::DESC_BYTES;
    end
  endfunction

  // Result checker: one compare per accepted descriptor transfer
  always @(posedge clk_i) begin : chk
    desc_t got;
    desc_t want;
    if (rst_ni && desc.valid && desc.ready) begin
      got = '{desc.desc_addr, desc.src_addr, desc.next_addr, desc.byte_count,
              desc.control, desc.last, desc.too_long};
      descs_checked++;
      if (got.too_long) long_results++;
      if (ring_desc_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected descriptor, expected none, got %s", $time, fmt_desc(got));
      end else begin
        want = ring_desc_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: descriptor differs\n  expected %s\n  actual   %s",
                   $time, fmt_desc(want), fmt_desc(got));
        end
      end
    end
  end

  // One request transfer; valid stays high on return so back-to-back sends work
  task automatic send_req(input xfer_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.start_addr <= r.start_addr;
    req.length     <= r.length;
    req.table_base <= r.table_base;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_ring(r);
    if (r.length != '0) requests_sent++;
  endtask

  task automatic send_fields(input logic [sgdrb_pkg::ADDR_W-1:0] start_addr,
                             input logic [sgdrb_pkg::LEN_W-1:0] length,
                             input logic [sgdrb_pkg::ADDR_W-1:0] table_base);
    send_req('{start_addr: start_addr, length: length, table_base: table_base});
  endtask

  // Drop valid, let every owed descriptor drain, then keep waiting
  // for a zero-length request that is still in flight.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (ring_desc_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_chunk(input logic [sgdrb_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    chunk_reg = value;
  endtask

  function automatic xfer_req_t rand_req();
    xfer_req_t   r;
    int unsigned chunk;
    int unsigned lo;
    int unsigned ndesc;
    int unsigned pick;
    chunk = (chunk_reg == '0) ? 1 : chunk_reg;
    pick  = $urandom_range(99);
    r.start_addr = $urandom;
    if ($urandom_range(7) == 0) r.start_addr = 32'hFFFF_FFFF - $urandom_range(4095);
    r.table_base = $urandom;
    if ($urandom_range(3) != 0) r.table_base[4:0] = 5'd0;
    if ($urandom_range(7) == 0) r.table_base[31:12] = '1;
    lo = sgdrb_pkg::MAX_DESCRIPTORS * chunk + 1;
    if (pick < 8) begin
      r.length = '0;
    end else if (pick < 18 && lo <= LEN_MAX) begin
      r.length = $urandom_range(1) ? sgdrb_pkg::LEN_W'(lo)
                                   : sgdrb_pkg::LEN_W'($urandom_range(LEN_MAX, lo));
    end else begin
      pick = $urandom_range(9);
      if (pick < 7)      ndesc = $urandom_range(4, 1);
      else if (pick < 9) ndesc = $urandom_range(20, 5);
      else               ndesc = $urandom_range(sgdrb_pkg::MAX_DESCRIPTORS, 21);
      r.length = sgdrb_pkg::LEN_W'($urandom_range(ndesc * chunk, (ndesc - 1) * chunk + 1));
    end
    return r;
  endfunction

  // Reset chunk size: boundaries of one and 64 chunks, too long, wraps, odd base
  task automatic test_reset_chunk();
    send_fields(32'h0000_1000, 22'd0, 32'h0000_2000);
    send_fields(32'h0000_0000, 22'd1, 32'h0000_0000);
    send_fields(32'hFFFF_FFFF, 22'd65280, 32'hFFFF_FFE0);
    send_fields(32'hFFFF_FFFF, 22'd65281, 32'hFFFF_FFE0);
    send_fields(32'hFFFF_0000, 22'd4177920, 32'h8000_0000);
    send_fields(32'h1234_5678, 22'd4177921, 32'h0000_0100);
    send_fields(32'hFFFF_FFFF, 22'h3F_FFFF, 32'hFFFF_FFFF);
    send_fields(32'h1234_5678, 22'd200000, 32'h0000_0013);
    send_fields(32'hFFFF_FFFF, 22'd195840, 32'hFFFF_FFFF);
  endtask

  // Chunk sizes zero and one: zero acts as one byte per descriptor
  task automatic test_small_chunks();
    set_chunk(16'd0);
    send_fields(32'hAAAA_AAAA, 22'd1, 32'h5555_5540);
    send_fields(32'hFFFF_FFE0, 22'd64, 32'hFFFF_FC00);
    send_fields(32'h0000_0000, 22'd65, 32'h0000_0000);
    send_fields(32'h0000_0000, 22'd0, 32'h0000_0000);
    set_chunk(16'd1);
    send_fields(32'h5555_5555, 22'd2, 32'hAAAA_AAA0);
    send_fields(32'h0000_0001, 22'd64, 32'h0000_0020);
  endtask

  // Largest chunk size: the longest legal request and the field maximum
  task automatic test_max_chunk();
    set_chunk(16'hFFFF);
    send_fields(32'h0000_0000, 22'd4194240, 32'hFFFF_FF00);
    send_fields(32'hFFFF_FFFF, 22'h3F_FFFF, 32'h0000_0000);
    send_fields(32'h8000_0000, 22'd65535, 32'h0000_0040);
    send_fields(32'h7FFF_FFFF, 22'd65536, 32'h7FFF_FFE0);
  endtask

  task automatic test_random_phase(input logic [sgdrb_pkg::CNT_W-1:0] chunk,
                                   input int send_pct, input int recv_pct,
                                   input bit pause_midway);
    xfer_req_t r;
    int        counted;
    set_chunk(chunk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      r = rand_req();
      send_req(r);
      if (r.length != '0) begin
        counted++;
        // hold the request side until the ring has fully drained
        if (pause_midway && counted == PHASE_ITEMS / 2) wait_idle();
      end
    end
  endtask

  task automatic finish_run();
    wait_idle();
    $display("Covered %0d requests and %0d descriptors (%0d too long) over chunk sizes",
             requests_sent, descs_checked, long_results);
    $display("reset, 0, 1, max and random, with sender idling and receiver stalls.");
    if (errors == 0) begin
      $display("sg_dma_descriptor_ring_builder_top: match");
    end else begin
      $display("sg_dma_descriptor_ring_builder_top: mismatch");
    end
    $finish;
  endtask

  initial begin
    req.valid      <= 1'b0;
    req.start_addr <= '0;
    req.length     <= '0;
    req.table_base <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_chunk();
    test_small_chunks();
    test_max_chunk();
    test_random_phase(sgdrb_pkg::CHUNK_RESET, 0, 0, 1'b0);
    test_random_phase(sgdrb_pkg::CNT_W'($urandom_range(300, 1)), 53, 0, 1'b0);
    test_random_phase(16'hFFFF, 0, 53, 1'b1);
    test_random_phase(16'd1, 37, 37, 1'b0);
    test_random_phase(sgdrb_pkg::CNT_W'($urandom_range(65535, 2)), 37, 37, 1'b0);
    finish_run();
  end

endmodule

### sg_dma_descriptor_ring_builder_top.f
sv/sgdrb_pkg.sv
sv/sgdrb_req_if.sv
sv/sgdrb_desc_if.sv
sv/sgdrb_sequencer.sv
sv/sgdrb_datapath.sv
sv/sg_dma_descriptor_ring_builder_top.sv
tb/testbench.sv
